FILE: src/cbdp_pkg.sv
// Shared constants, types and floating-point helper functions of the codebook dot product.
package cbdp_pkg;

	localparam int CBDP_TABLE_DEPTH = 4096;
	localparam int CBDP_IDX_W = 12;
	localparam int CBDP_XW = 50;
	localparam logic [31:0] CBDP_CANON_NAN = 32'h7FC0_0000;

	typedef struct packed {
		logic [1:0] count;
		logic       row_end;
	} cbdp_tag_t;

	function automatic logic [31:0] cbdp_half_to_single(input logic [15:0] h);
		logic [4:0] ex;
		logic [9:0] man;
		logic [9:0] mn;
		logic [3:0] lz;
		logic       found;
		ex = h[14:10];
		man = h[9:0];
		lz = 4'd0;
		found = 1'b0;
		for (int i = 9; i >= 0; i--) begin
			if (!found && man[i]) begin
				lz = 4'(9 - i);
				found = 1'b1;
			end
		end
		// The leading one of a subnormal is shifted out to become the hidden bit.
		mn = man << (lz + 4'd1);
		if (ex == 5'd0) begin
			if (man == 10'd0)
				return {h[15], 31'd0};
			return {h[15], 8'd112 - {4'd0, lz}, mn, 13'd0};
		end
		if (ex == 5'h1F)
			return {h[15], 8'hFF, man, 13'd0};
		return {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
	endfunction

	function automatic logic [5:0] cbdp_lzc(input logic [CBDP_XW-1:0] x);
		logic [5:0] lz;
		lz = 6'(CBDP_XW);
		for (int i = 0; i < CBDP_XW; i++) begin
			if (x[i])
				lz = 6'(CBDP_XW - 1 - i);
		end
		return lz;
	endfunction

	// xn has its leading one at the top bit; eb is the biased exponent of that bit.
	function automatic logic [31:0] cbdp_round_pack(input logic sign,
			input logic signed [11:0] eb, input logic [CBDP_XW-1:0] xn);
		logic [CBDP_XW-1:0] xs;
		logic [CBDP_XW-1:0] mask;
		logic [11:0]        shw;
		logic [5:0]         sh;
		logic [30:0]        mag;
		logic [23:0]        m;
		logic               g;
		logic               st;
		logic               inc;
		logic               lost;
		if (xn == '0)
			return {sign, 31'd0};
		if (eb >= 12'sd255)
			return {sign, 8'hFF, 23'd0};
		if (eb >= 12'sd1) begin
			g = xn[25];
			st = |xn[24:0];
			inc = g & (st | xn[26]);
			mag = {eb[7:0], xn[48:26]} + 31'(inc);
			return {sign, mag};
		end
		if (eb < -12'sd24)
			return {sign, 31'd0};
		shw = 12'(12'sd1 - eb);
		sh = shw[5:0];
		mask = ({{(CBDP_XW-1){1'b0}}, 1'b1} << sh) - {{(CBDP_XW-1){1'b0}}, 1'b1};
		lost = |(xn & mask);
		xs = xn >> sh;
		g = xs[25];
		st = (|xs[24:0]) | lost;
		inc = g & (st | xs[26]);
		m = xs[49:26] + 24'(inc);
		return {sign, 7'd0, m};
	endfunction

endpackage

FILE: src/cbdp_lane.sv
// One multiply lane: widens a half-precision centroid and multiplies it by an FP32 activation.
module cbdp_lane (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] centroid,
	input  logic [31:0] act,
	output logic [31:0] prod
);
	import cbdp_pkg::*;

	logic [31:0] wa_s2;
	logic [31:0] act_s2;

	logic               sa;
	logic               sb;
	logic [7:0]         ea;
	logic [7:0]         eb;
	logic [23:0]        ma;
	logic [23:0]        mb;
	logic               a_nan;
	logic               b_nan;
	logic               a_inf;
	logic               b_inf;
	logic               a_zero;
	logic               b_zero;
	logic [47:0]        p_s3;
	logic signed [11:0] esum_s3;
	logic               sign_s3;
	logic               spec_s3;
	logic [31:0]        specval_s3;

	logic [CBDP_XW-1:0] xw;
	logic [5:0]         lz;
	logic [CBDP_XW-1:0] xn_s4;
	logic signed [11:0] exp_s4;
	logic               sign_s4;
	logic               spec_s4;
	logic [31:0]        specval_s4;

	logic [31:0] prod_s5;

	always_comb begin
		sa = wa_s2[31];
		sb = act_s2[31];
		ea = (wa_s2[30:23] == 8'd0) ? 8'd1 : wa_s2[30:23];
		eb = (act_s2[30:23] == 8'd0) ? 8'd1 : act_s2[30:23];
		ma = {wa_s2[30:23] != 8'd0, wa_s2[22:0]};
		mb = {act_s2[30:23] != 8'd0, act_s2[22:0]};
		a_nan = (wa_s2[30:23] == 8'hFF) && (wa_s2[22:0] != 23'd0);
		b_nan = (act_s2[30:23] == 8'hFF) && (act_s2[22:0] != 23'd0);
		a_inf = (wa_s2[30:23] == 8'hFF) && (wa_s2[22:0] == 23'd0);
		b_inf = (act_s2[30:23] == 8'hFF) && (act_s2[22:0] == 23'd0);
		a_zero = wa_s2[30:0] == 31'd0;
		b_zero = act_s2[30:0] == 31'd0;
	end

	always_comb begin
		xw = {p_s3, 2'b00};
		lz = cbdp_lzc(xw);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wa_s2 <= cbdp_half_to_single(centroid);
			act_s2 <= act;

			p_s3 <= ma * mb;
			esum_s3 <= $signed({4'd0, ea}) + $signed({4'd0, eb});
			sign_s3 <= sa ^ sb;
			spec_s3 <= a_nan | b_nan | a_inf | b_inf;
			if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
				specval_s3 <= CBDP_CANON_NAN;
			else
				specval_s3 <= {sa ^ sb, 8'hFF, 23'd0};

			xn_s4 <= xw << lz;
			exp_s4 <= esum_s3 - 12'sd126 - $signed({6'd0, lz});
			sign_s4 <= sign_s3;
			spec_s4 <= spec_s3;
			specval_s4 <= specval_s3;

			prod_s5 <= spec_s4 ? specval_s4 : cbdp_round_pack(sign_s4, exp_s4, xn_s4);
		end
	end

	assign prod = prod_s5;

endmodule

FILE: src/cbdp_acc.sv
// Merging accumulator: adds the lane products into the running FP32 sum in order.
module cbdp_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [31:0]          prod_first,
	input  logic [31:0]          prod_second,
	input  cbdp_pkg::cbdp_tag_t  tag,
	output logic                 item_ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [31:0]          row_sum
);
	import cbdp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ALN  = 2'd1;
	localparam logic [1:0] ST_RND  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]  state_q;
	logic        sel_q;
	logic [1:0]  cnt_q;
	logic        end_q;
	logic [31:0] p0_q;
	logic [31:0] p1_q;
	logic [31:0] sum_q;
	logic [31:0] out_q;
	logic        ov_q;

	logic [CBDP_XW-1:0] r_q;
	logic signed [11:0] eb_q;
	logic               sb_q;
	logic               zs_q;
	logic               sp_q;
	logic [31:0]        spv_q;

	logic [31:0]        opb;
	logic [31:0]        big;
	logic [31:0]        sml;
	logic               a_nan;
	logic               b_nan;
	logic               a_inf;
	logic               b_inf;
	logic [7:0]         ebig;
	logic [7:0]         esml;
	logic [7:0]         d;
	logic [CBDP_XW-1:0] xb;
	logic [CBDP_XW-1:0] xs0;
	logic [CBDP_XW-1:0] xs;
	logic [CBDP_XW-1:0] mask;
	logic               lost;
	logic [CBDP_XW-1:0] rsum;

	logic [5:0]         lz;
	logic [CBDP_XW-1:0] xn;
	logic signed [11:0] en;
	logic [31:0]        rnd_res;

	logic blocked;
	logic last;
	logic emit_now;
	logic take;

	always_comb begin
		opb = sel_q ? p1_q : p0_q;
		a_nan = (sum_q[30:23] == 8'hFF) && (sum_q[22:0] != 23'd0);
		b_nan = (opb[30:23] == 8'hFF) && (opb[22:0] != 23'd0);
		a_inf = (sum_q[30:23] == 8'hFF) && (sum_q[22:0] == 23'd0);
		b_inf = (opb[30:23] == 8'hFF) && (opb[22:0] == 23'd0);
		if (sum_q[30:0] >= opb[30:0]) begin
			big = sum_q;
			sml = opb;
		end else begin
			big = opb;
			sml = sum_q;
		end
		ebig = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		esml = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		d = ebig - esml;
		xb = {1'b0, big[30:23] != 8'd0, big[22:0], 25'd0};
		xs0 = {1'b0, sml[30:23] != 8'd0, sml[22:0], 25'd0};
		// Bits shifted out below the alignment are folded into a sticky bit.
		if (d >= 8'(CBDP_XW)) begin
			mask = '0;
			xs = '0;
			lost = xs0 != '0;
		end else begin
			mask = ({{(CBDP_XW-1){1'b0}}, 1'b1} << d) - {{(CBDP_XW-1){1'b0}}, 1'b1};
			lost = |(xs0 & mask);
			xs = xs0 >> d;
		end
		xs[0] = xs[0] | lost;
		rsum = (big[31] == sml[31]) ? (xb + xs) : (xb - xs);
	end

	always_comb begin
		lz = cbdp_lzc(r_q);
		xn = r_q << lz;
		en = eb_q + 12'sd1 - $signed({6'd0, lz});
		if (sp_q)
			rnd_res = spv_q;
		else if (r_q == '0)
			rnd_res = {zs_q, 31'd0};
		else
			rnd_res = cbdp_round_pack(sb_q, en, xn);
	end

	always_comb begin
		blocked = ov_q && out_stall;
		last = sel_q || !cnt_q[1];
		emit_now = end_q && !blocked && ((state_q == ST_RND && last) || state_q == ST_FIN);
		item_ready = (state_q == ST_IDLE)
			|| (state_q == ST_RND && last && !(end_q && blocked))
			|| (state_q == ST_FIN && !(end_q && blocked));
		take = item_valid && item_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q <= 1'b0;
			cnt_q <= 2'd0;
			end_q <= 1'b0;
			sum_q <= 32'd0;
			ov_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_ALN: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					sum_q <= rnd_res;
					if (!last) begin
						sel_q <= 1'b1;
						state_q <= ST_ALN;
					end else if (end_q && blocked) begin
						state_q <= ST_FIN;
					end else begin
						if (end_q)
							sum_q <= 32'd0;
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					if (!(end_q && blocked)) begin
						if (end_q)
							sum_q <= 32'd0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (take) begin
				cnt_q <= tag.count;
				end_q <= tag.row_end;
				sel_q <= 1'b0;
				state_q <= (tag.count != 2'd0) ? ST_ALN : ST_FIN;
			end
			if (emit_now)
				ov_q <= 1'b1;
			else if (ov_q && !out_stall)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0_q <= prod_first;
			p1_q <= prod_second;
		end
		if (state_q == ST_ALN) begin
			r_q <= rsum;
			eb_q <= $signed({4'd0, ebig});
			sb_q <= big[31];
			zs_q <= sum_q[31] & opb[31];
			sp_q <= a_nan | b_nan | a_inf | b_inf;
			if (a_nan || b_nan || (a_inf && b_inf && (sum_q[31] != opb[31])))
				spv_q <= CBDP_CANON_NAN;
			else
				spv_q <= {a_inf ? sum_q[31] : opb[31], 8'hFF, 23'd0};
		end
		if (emit_now) begin
			if (state_q == ST_RND)
				out_q <= ((rnd_res[30:23] == 8'hFF) && (rnd_res[22:0] != 23'd0))
					? CBDP_CANON_NAN : rnd_res;
			else
				out_q <= ((sum_q[30:23] == 8'hFF) && (sum_q[22:0] != 23'd0))
					? CBDP_CANON_NAN : sum_q;
		end
	end

	assign out_valid = ov_q;
	assign row_sum = out_q;

	a_aln_then_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALN) |=> (state_q == ST_RND))
		else $error("alignment step not followed by rounding step");

	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_now |=> (sum_q == 32'd0))
		else $error("running sum not cleared after row result");

	a_rise_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(emit_now))
		else $error("result appeared without a row end");

	a_no_take_mid_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ALN) |-> !item_ready)
		else $error("new transaction taken while an add is in flight");

endmodule

FILE: src/codebook_dot_product_12bit_core.sv
// Top level of the codebook dot product: centroid table, two multiply lanes and the accumulator.
// A load transaction (operation 0) writes one half-precision centroid into the 4096-entry table
// and completes in the cycle it is accepted. A compute transaction reads both centroids in the
// same cycle from the two-read-port table, passes them through two four-stage multiply lanes
// side by side, and the accumulator then adds the products into the FP32 running sum in order,
// each add running as two steps (align and add, then normalise and round). The dependent adds
// set the rate: the accumulator takes no new compute transaction until the last add of the
// current one is being rounded. row_sum appears in an output register, and input is accepted
// while a result waits, until the pipeline fills.
module codebook_dot_product_12bit_core #(
	parameter int TABLE_DEPTH = cbdp_pkg::CBDP_TABLE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [11:0] entry_index,
	input  logic [15:0] entry_value,
	input  logic [23:0] packed_pair,
	input  logic [31:0] act_first,
	input  logic [31:0] act_second,
	input  logic [1:0]  pair_count,
	input  logic        row_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] row_sum
);
	import cbdp_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);

	logic [15:0] table_mem [TABLE_DEPTH];

	logic        accept;
	logic        adv;
	logic        acc_ready;
	logic [15:0] c0_s1;
	logic [15:0] c1_s1;
	logic [31:0] a0_s1;
	logic [31:0] a1_s1;
	logic [31:0] prod0;
	logic [31:0] prod1;
	logic        v_s1;
	logic        v_s2;
	logic        v_s3;
	logic        v_s4;
	logic        v_s5;
	cbdp_tag_t   tag_s1;
	cbdp_tag_t   tag_s2;
	cbdp_tag_t   tag_s3;
	cbdp_tag_t   tag_s4;
	cbdp_tag_t   tag_s5;

	assign in_stall = v_s5 && !acc_ready;
	assign adv = !in_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (accept && !operation)
			table_mem[entry_index[IDX_W-1:0]] <= entry_value;
		if (accept && operation) begin
			c0_s1 <= table_mem[packed_pair[IDX_W-1:0]];
			c1_s1 <= table_mem[packed_pair[CBDP_IDX_W +: IDX_W]];
			a0_s1 <= act_first;
			a1_s1 <= act_second;
			tag_s1 <= '{count: pair_count, row_end: row_end};
		end
		if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept && operation;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	cbdp_lane u_lane0 (
		.clk      (clk),
		.en       (adv),
		.centroid (c0_s1),
		.act      (a0_s1),
		.prod     (prod0)
	);

	cbdp_lane u_lane1 (
		.clk      (clk),
		.en       (adv),
		.centroid (c1_s1),
		.act      (a1_s1),
		.prod     (prod1)
	);

	cbdp_acc u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (v_s5),
		.prod_first  (prod0),
		.prod_second (prod1),
		.tag         (tag_s5),
		.item_ready  (acc_ready),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.row_sum     (row_sum)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s5 && !acc_ready))
		else $error("input stalled while the lane output was free");

	a_held_stage: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> v_s5)
		else $error("lane output lost while stalled");

	a_take_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && acc_ready && !v_s4) |=> !v_s5)
		else $error("lane output taken twice");

endmodule
